>>> design/pscn_pkg.sv
// Shared types and constants for the same-color pixel neighbor block.
package pscn_pkg;

    localparam int IDX_W   = 12;
    localparam int COLOR_W = 8;
    localparam int REG_W   = 7;
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int AREA_W  = 2 * REG_W;

    // store reads per query: the pixel itself, then four neighbors
    localparam int RD_STEPS = 5;

    localparam logic [REG_W-1:0] SIDE_RESET = 7'd64;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] neighbor_index;
        t_dir             direction;
        logic             has_neighbor;
        logic             out_of_range;
        logic             last;
    } t_out;

endpackage

>>> design/pscn_ram.sv
// Generic single-port RAM with registered read data.
module pscn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pscn_div.sv
// Bit-serial restoring divider: pixel index by image width, one quotient bit per cycle.
module pscn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pscn_pkg::IDX_W-1:0]  i_dividend,
    input  logic [pscn_pkg::REG_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pscn_pkg::IDX_W-1:0]  o_quot,
    output logic [pscn_pkg::REG_W-1:0]  o_rem
);
    import pscn_pkg::*;

    localparam int CNT_W = $clog2(IDX_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(IDX_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_q;
    logic [REG_W-1:0] r_rem;
    logic [REG_W-1:0] r_d;

    logic [REG_W:0] trial;
    logic [REG_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_q[IDX_W-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[IDX_W-2:0], ge};
            r_rem <= ge ? diff[REG_W-1:0] : trial[REG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

>>> design/pixel_same_color_neighbors.sv
// Top level: pixel store with same-color 4-neighbor query sequencer.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is a
// pixel write or a neighbor query. A write lands in the pixel store in the
// accept cycle, yields no result, and the block stays ready.
// A query runs a bit-serial divide (12 quotient bits; index by width) to get
// column and row, then reads through the single store port (own pixel, left,
// up, right, down), then emits its results; o_in_stall is high throughout.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per
// matching neighbor in left, up, right, down order, last set on the final
// one; an empty result when nothing matches; a single out_of_range result
// for an index at or past width * height (no divide or reads).
// The output register holds a stalled result; emission waits behind it,
// and once the final result is loaded the block takes the next transaction.
// Config writes (i_cfg_we) update width/height; the user must write only while idle; the block does not enforce it.
// Reset (synchronous, i_rst_n low) sets width and height to 64 and empties
// the output; pixel store contents are left as they are.
module pixel_same_color_neighbors #(
    parameter int MAX_PIXELS = 4096,
    parameter int MAX_SIDE   = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pscn_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pscn_pkg::t_out             o_out_data,
    input  logic                       i_cfg_we,
    input  pscn_pkg::t_cfg_reg         i_cfg_idx,
    input  logic [pscn_pkg::REG_W-1:0] i_cfg_data
);
    import pscn_pkg::*;

    localparam int AW  = $clog2(MAX_PIXELS);
    // compare widths wide enough for the index and the parameter bound
    localparam int PCW = ($clog2(MAX_PIXELS + 1) > IDX_W) ? $clog2(MAX_PIXELS + 1) : IDX_W + 1;
    localparam int SCW = ($clog2(MAX_SIDE + 1) > REG_W) ? $clog2(MAX_SIDE + 1) : REG_W + 1;
    localparam int STEP_W = $clog2(RD_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RD_STEPS);

    function automatic logic in_store(input logic [IDX_W-1:0] a);
        return PCW'(a) < PCW'(MAX_PIXELS);
    endfunction

    // zero acts as one, anything past MAX_SIDE acts as MAX_SIDE
    function automatic logic [REG_W-1:0] side_of(input logic [REG_W-1:0] r);
        logic [REG_W-1:0] s;
        s = r;
        if (r == '0) begin
            s = REG_W'(1);
        end else if (SCW'(r) > SCW'(MAX_SIDE)) begin
            s = REG_W'(MAX_SIDE);
        end
        return s;
    endfunction

    // state
    t_state            r_state;
    t_state            n_state;
    logic [REG_W-1:0]  r_width;
    logic [REG_W-1:0]  r_height;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out              r_out;

    // per-query working registers
    logic [IDX_W-1:0]  r_idx;
    logic [REG_W-1:0]  r_w;
    logic [REG_W-1:0]  r_h;
    logic              r_oor;
    logic [REG_W-1:0]  r_col;
    logic [REG_W-1:0]  r_row;
    logic              r_rd_ok;
    logic [PIX_W-1:0]  r_self;
    logic [3:0]        r_match;

    // combinational
    logic [REG_W-1:0]  w_side;
    logic [REG_W-1:0]  h_side;
    logic [AREA_W-1:0] area;
    logic              in_acc;
    logic              is_query;
    logic              q_oor;
    logic [3:0]        ok;
    logic [STEP_W-1:0] step_m1;
    logic [STEP_W-1:0] step_m2;
    logic [IDX_W-1:0]  rd_addr;
    logic [PIX_W-1:0]  rd_pix;
    t_dir              sel;
    logic [3:0]        rest;
    t_out              res;
    logic              out_free;
    logic              emit_load;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata;

    logic              div_start;
    logic              div_done;
    logic [IDX_W-1:0]  div_quot;
    logic [REG_W-1:0]  div_rem;

    function automatic logic [IDX_W-1:0] cand(input t_dir d, input logic [IDX_W-1:0] idx,
                                              input logic [REG_W-1:0] w);
        logic [IDX_W-1:0] c;
        c = idx;
        unique case (d)
            DIR_LEFT:  c = idx - IDX_W'(1);
            DIR_UP:    c = idx - IDX_W'(w);
            DIR_RIGHT: c = idx + IDX_W'(1);
            DIR_DOWN:  c = idx + IDX_W'(w);
        endcase
        return c;
    endfunction

    assign w_side   = side_of(r_width);
    assign h_side   = side_of(r_height);
    assign area     = AREA_W'(w_side) * AREA_W'(h_side);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_query = i_in_data.command == CMD_QUERY;
    assign q_oor    = AREA_W'(i_in_data.pixel_index) >= area;

    // bounds, right and down strict
    assign ok[0] = r_col != '0;
    assign ok[1] = r_row != '0;
    assign ok[2] = ({1'b0, r_col} + 1'b1) < {1'b0, r_w};
    assign ok[3] = ({1'b0, r_row} + 1'b1) < {1'b0, r_h};

    assign step_m1 = r_step - STEP_W'(1);
    assign step_m2 = r_step - STEP_W'(2);
    assign rd_addr = (r_step == '0) ? r_idx : cand(t_dir'(step_m1[1:0]), r_idx, r_w);
    // entries past the store read as black
    assign rd_pix  = r_rd_ok ? ram_rdata : '0;

    // lowest pending match goes first
    always_comb begin
        sel = DIR_DOWN;
        priority if (r_match[0]) begin
            sel = DIR_LEFT;
        end else if (r_match[1]) begin
            sel = DIR_UP;
        end else if (r_match[2]) begin
            sel = DIR_RIGHT;
        end else begin
            sel = DIR_DOWN;
        end
    end

    assign rest = r_match & ~(4'b0001 << sel);

    always_comb begin
        res = '0;
        if (r_oor) begin
            res.out_of_range = 1'b1;
            res.last         = 1'b1;
        end else if (r_match == '0) begin
            res.last = 1'b1;
        end else begin
            res.neighbor_index = cand(sel, r_idx, r_w);
            res.direction      = sel;
            res.has_neighbor   = 1'b1;
            res.last           = rest == '0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = q_oor ? S_EMIT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free && res.last) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // state outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = AW'(rd_addr);
        ram_wdata = {i_in_data.red, i_in_data.green, i_in_data.blue};
        div_start = 1'b0;
        emit_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                ram_addr  = AW'(i_in_data.pixel_index);
                ram_we    = in_acc && !is_query && in_store(i_in_data.pixel_index);
                div_start = in_acc && is_query && !q_oor;
            end
            S_DIV:  ;
            S_READ: ;
            S_EMIT: begin
                emit_load = out_free;
            end
        endcase
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= SIDE_RESET;
            r_height    <= SIDE_RESET;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                endcase
            end
            if (div_done) begin
                r_step <= '0;
            end else if (r_state == S_READ) begin
                r_step <= r_step + 1'b1;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_query) begin
            r_idx   <= i_in_data.pixel_index;
            r_w     <= w_side;
            r_h     <= h_side;
            r_oor   <= q_oor;
            r_match <= '0;
        end
        if (div_done) begin
            r_col <= div_rem;
            r_row <= div_quot[REG_W-1:0];
        end
        if (r_state == S_READ) begin
            r_rd_ok <= in_store(rd_addr);
            if (r_step == STEP_W'(1)) begin
                r_self <= rd_pix;
            end else if (r_step > STEP_W'(1)) begin
                r_match[step_m2[1:0]] <= ok[step_m2[1:0]] && (rd_pix == r_self);
            end
        end
        if (emit_load) begin
            r_out   <= res;
            r_match <= rest;
        end
    end

    pscn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in_data.pixel_index),
        .i_divisor  (w_side),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pscn_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule

>>> design/pscn_chk.sv
// Port-level checker for the same-color pixel neighbor block, with its bind.
module pscn_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input pscn_pkg::t_in              i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input pscn_pkg::t_out             o_out_data,
    input logic                       i_cfg_we,
    input pscn_pkg::t_cfg_reg         i_cfg_idx,
    input logic [pscn_pkg::REG_W-1:0] i_cfg_data
);
    import pscn_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.command == CMD_WRITE |=> !o_in_stall)
        else $error("pixel write left the block busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.command == CMD_QUERY |=> o_in_stall)
        else $error("query did not start");

    a_mid_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_in_stall)
        else $error("new transaction taken before query finished");

endmodule

bind pixel_same_color_neighbors pscn_chk u_chk (.*);

>>> test/pixel_same_color_neighbors_test.sv
// Self-checking testbench for the same-color pixel neighbor block.
`timescale 1ns / 1ps

module pixel_same_color_neighbors_test;
    import pscn_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int SIDE_MAX    = 64;
    localparam int SETTLE      = 40;        // covers the longest unstalled query
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    t_in            in_data  = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    t_out           out_data;
    logic           cfg_we   = 1'b0;
    t_cfg_reg       cfg_idx  = CFG_WIDTH;
    logic [REG_W-1:0] cfg_data = '0;

    // Transactions waiting for the driver, and results waiting for the monitor.
    t_in  pending_items[$];
    t_out expected_results[$];

    // Predictor copy of the image and of the size registers (raw register values,
    // clamping is applied where they are used).
    logic [PIX_W-1:0] image_model [STORE_DEPTH];
    logic [REG_W-1:0] width_reg  = SIDE_RESET;
    logic [REG_W-1:0] height_reg = SIDE_RESET;

    // Pixels that the generated traffic has written so far. Queries are only
    // generated once the pixel and its in-bounds neighbors are in this map,
    // so no unwritten store entry ever decides a result.
    bit planned_written [STORE_DEPTH];
    int unsigned planned_count = 0;

    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    t_out        want;

    pixel_same_color_neighbors u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Queue appends.
    function automatic void add_pending(t_in item);
        pending_items.insert(pending_items.size(), item);
    endfunction

    function automatic void add_expected(t_out r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Register value 0 behaves as 1, anything past the maximum side as the maximum.
    function automatic int unsigned effective_side(logic [REG_W-1:0] r);
        if (r == '0) return 1;
        if (r > SIDE_MAX) return SIDE_MAX;
        return 32'(r);
    endfunction

    // Applies one accepted transaction to the image copy; for a query, queues
    // the results the block must produce, in left, up, right, down order.
    function automatic void predict_neighbors(t_in item);
        int unsigned w, h, idx, col, row, found;
        int unsigned cand [4];
        bit          ok [4];
        t_dir        dirs [4];
        t_out        hits [4];
        t_out        res;
        logic [PIX_W-1:0] self_color;

        if (item.command == CMD_WRITE) begin
            image_model[item.pixel_index] = {item.red, item.green, item.blue};
            return;
        end

        w   = effective_side(width_reg);
        h   = effective_side(height_reg);
        idx = 32'(item.pixel_index);
        res = '0;

        if (idx >= w * h) begin
            res.out_of_range = 1'b1;
            res.last         = 1'b1;
            add_expected(res);
            return;
        end

        col = idx % w;
        row = idx / w;
        self_color = image_model[idx];

        dirs[0] = DIR_LEFT;  ok[0] = col > 0;      cand[0] = idx - 1;
        dirs[1] = DIR_UP;    ok[1] = row > 0;      cand[1] = idx - w;
        dirs[2] = DIR_RIGHT; ok[2] = col + 1 < w;  cand[2] = idx + 1;
        dirs[3] = DIR_DOWN;  ok[3] = row + 1 < h;  cand[3] = idx + w;

        found = 0;
        for (int i = 0; i < 4; i++) begin
            if (ok[i] && image_model[cand[i]] == self_color) begin
                hits[found]                = '0;
                hits[found].neighbor_index = cand[i][IDX_W-1:0];
                hits[found].direction      = dirs[i];
                hits[found].has_neighbor   = 1'b1;
                found++;
            end
        end

        if (found == 0) begin
            // nothing matched: single empty result closes the query
            res.last = 1'b1;
            add_expected(res);
        end else begin
            hits[found - 1].last = 1'b1;
            for (int i = 0; i < found; i++) add_expected(hits[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    // Small palette so neighbors often match; black and white hit the color extremes.
    function automatic logic [PIX_W-1:0] palette_color();
        case ($urandom_range(3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h3C9A55;
            default: return 24'hC365AA;
        endcase
    endfunction

    function automatic void queue_write(int unsigned idx, logic [PIX_W-1:0] color);
        t_in item;
        item.command     = CMD_WRITE;
        item.pixel_index = idx[IDX_W-1:0];
        {item.red, item.green, item.blue} = color;
        add_pending(item);
        planned_written[idx] = 1'b1;
        planned_count++;
    endfunction

    function automatic void fill_pixel(int unsigned idx);
        if (!planned_written[idx]) queue_write(idx, palette_color());
    endfunction

    // Queries an index; any pixel the query will read that is still unwritten
    // gets a palette write ahead of it. Color fields of a query are don't-care,
    // so they carry random values.
    function automatic void queue_query(int unsigned idx);
        int unsigned w, h, col, row;
        t_in item;
        w = effective_side(width_reg);
        h = effective_side(height_reg);
        if (idx < w * h) begin
            col = idx % w;
            row = idx / w;
            fill_pixel(idx);
            if (col > 0)     fill_pixel(idx - 1);
            if (row > 0)     fill_pixel(idx - w);
            if (col + 1 < w) fill_pixel(idx + 1);
            if (row + 1 < h) fill_pixel(idx + w);
        end
        item.command     = CMD_QUERY;
        item.pixel_index = idx[IDX_W-1:0];
        item.red         = COLOR_W'($urandom);
        item.green       = COLOR_W'($urandom);
        item.blue        = COLOR_W'($urandom);
        add_pending(item);
        planned_count++;
    endfunction

    // Mostly queries inside the image, some outside it, and writes that
    // repaint pixels inside the image or anywhere in the store.
    task automatic random_traffic(int unsigned count);
        int unsigned area, stop, idx;
        logic [PIX_W-1:0] color;
        area = effective_side(width_reg) * effective_side(height_reg);
        stop = planned_count + count;
        while (planned_count < stop) begin
            if ($urandom_range(99) < 35) begin
                if ($urandom_range(3) == 0) idx = $urandom_range(STORE_DEPTH - 1);
                else                        idx = $urandom_range(area - 1);
                if ($urandom_range(3) == 0) color = PIX_W'($urandom);
                else                        color = palette_color();
                queue_write(idx, color);
            end else if (area < STORE_DEPTH && $urandom_range(9) == 0) begin
                queue_query($urandom_range(STORE_DEPTH - 1, area));
            end else begin
                queue_query($urandom_range(area - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Blocks until every queued transaction went in and every result came out,
    // then gives the block time to finish any trailing work. Checked on the
    // falling edge so the driver's and monitor's updates have settled.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [REG_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH) width_reg  = value;
        else                  height_reg = value;
    endtask

    task automatic set_size(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic run_phase(logic [REG_W-1:0] w, logic [REG_W-1:0] h,
                             int unsigned idle, int unsigned stall, int unsigned count);
        in_idle_pct   = idle;
        out_stall_pct = stall;
        set_size(w, h);
        random_traffic(count);
        wait_idle();
    endtask

    function automatic string describe(t_out r);
        return $sformatf("idx=%0d dir=%0d has=%0b oor=%0b last=%0b",
                         r.neighbor_index, r.direction, r.has_neighbor,
                         r.out_of_range, r.last);
    endfunction

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("ERROR @%0d: %s", cycle_count, msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued transactions; the prediction runs on the edge
    // where the block takes one. A new transaction may follow immediately,
    // so valid is only written once per edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) predict_neighbors(in_data);
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation
    // and drives the random output stall.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                flag_error({"unexpected result ", describe(out_data)});
            end else begin
                want = expected_results.pop_front();
                if (out_data.neighbor_index !== want.neighbor_index ||
                    out_data.direction      !== want.direction      ||
                    out_data.has_neighbor   !== want.has_neighbor   ||
                    out_data.out_of_range   !== want.out_of_range   ||
                    out_data.last           !== want.last) begin
                    flag_error({"expected ", describe(want), ", got ", describe(out_data)});
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset size 64x64. Top-left corner: no left or up neighbor,
        // right one matches, down one does not.
        queue_write(0, 24'h000000);
        queue_write(1, 24'h000000);
        queue_write(64, 24'hFFFFFF);
        queue_query(0);
        // Bottom-right corner: strict right/down bounds, left and up match.
        queue_write(4095, 24'hFFFFFF);
        queue_write(4094, 24'hFFFFFF);
        queue_write(4031, 24'hFFFFFF);
        queue_query(4095);
        wait_idle();

        // 3x3 of one color: center matches on all four sides, then indices
        // just past and far past the image, then a center with no match.
        set_size(3, 3);
        for (int i = 0; i < 9; i++) queue_write(i, 24'h808080);
        queue_query(4);
        queue_query(9);
        queue_query(4095);
        queue_write(4, 24'h7F7F7F);
        queue_query(4);
        wait_idle();

        // Random phases across sizes and traffic shapes. A width of 0 acts as 1
        // and sides past 64 act as 64.
        run_phase(8, 8, 0, 0, 30);
        run_phase(0, 127, 85, 0, 30);
        run_phase(64, 1, 0, 85, 30);
        run_phase(5, 7, 36, 36, 30);
        run_phase(127, 100, 36, 36, 30);
        run_phase(2, 2, 85, 0, 25);
        run_phase(1, 1, 0, 85, 15);

        // Short bursts, each fully drained before the next one starts.
        in_idle_pct   = 36;
        out_stall_pct = 36;
        set_size(13, 3);
        for (int b = 0; b < 8; b++) begin
            random_traffic(4);
            wait_idle();
        end

        run_phase(64, 64, 0, 0, 30);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/pscn_pkg.sv
design/pscn_ram.sv
design/pscn_div.sv
design/pixel_same_color_neighbors.sv
design/pscn_chk.sv
test/pixel_same_color_neighbors_test.sv
